// File: rtl/cmwc_pkg.sv
// Shared types, constants and helpers for the CMWC random generator.
// Used by every module under rtl/ except cmwc_ram; depends on nothing else.
package cmwc_pkg;

  localparam int unsigned LAG_DEPTH_DEF = 4096;
  localparam int unsigned MAX_TRIES     = 64;
  localparam int unsigned TRY_W         = $clog2(MAX_TRIES);

  localparam logic [31:0] MULT_RESET = 32'd18782;
  localparam logic [31:0] CARRY_SEED = 32'd123;
  localparam logic [31:0] WORD_TOP   = 32'hFFFF_FFFE;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

  // Register index of the multiplier on the configuration port
  localparam logic REG_MULT = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RAW     = 2'd1,
    OP_BOUNDED = 2'd2,
    OP_RANGE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ADD,
    ST_FIN,
    ST_CHECK
  } state_t;

  // Strobes from the sequencer to the arithmetic unit
  typedef struct packed {
    logic seed;
    logic mul;
    logic add;
    logic fin;
  } step_ctl_t;

  // Smallest all-ones mask that covers n
  function automatic logic [31:0] cover_mask(input logic [31:0] n);
    logic [31:0] m;
    m = n;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction

endpackage

// File: rtl/cmwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module cmwc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/cmwc_step.sv
// Shared CMWC arithmetic unit: multiply, add carry, fold carry and complement.
// Depends on cmwc_pkg for step_ctl_t and constants.
module cmwc_step import cmwc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  step_ctl_t   ctl,
  input  logic [31:0] multiplier,
  input  logic [31:0] lag_word,
  output logic [31:0] word
);

  logic [63:0] prod;
  logic [63:0] t;
  logic [31:0] carry;
  logic [32:0] fold;
  logic        ov;
  logic [31:0] x;

  // x < carry happens exactly when the fold overflows
  assign fold = {1'b0, t[31:0]} + {1'b0, t[63:32]};
  assign ov   = fold[32];
  assign x    = fold[31:0] + {31'd0, ov};

  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= CARRY_SEED;
    end else if (ctl.seed) begin
      carry <= CARRY_SEED;
    end else if (ctl.fin) begin
      carry <= t[63:32] + {31'd0, ov};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= multiplier * lag_word;
    end
    if (ctl.add) begin
      t <= prod + {32'd0, carry};
    end
    if (ctl.fin) begin
      word <= WORD_TOP - x;
    end
  end

endmodule

// File: rtl/cmwc_ctrl.sv
// Sequencer for the CMWC generator: loads, tries, rejection and result.
// Depends on cmwc_pkg; drives cmwc_step and the lag table RAM.
module cmwc_ctrl import cmwc_pkg::*; #(
  parameter int unsigned LAG_DEPTH = LAG_DEPTH_DEF,
  localparam int unsigned PTR_W    = $clog2(LAG_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         op,
  input  logic [11:0]        seed_index,
  input  logic [31:0]        seed_word,
  input  logic [31:0]        bound,
  input  logic signed [31:0] range_low,
  input  logic signed [31:0] range_high,
  input  logic [31:0]        word,
  output step_ctl_t          ctl,
  output logic               ram_we,
  output logic [PTR_W-1:0]   ram_waddr,
  output logic [31:0]        ram_wdata,
  output logic [PTR_W-1:0]   ram_raddr,
  output logic               busy,
  output logic               done,
  output logic [31:0]        value
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LAG_DEPTH - 1);

  state_t           state, state_next;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] ptr_inc;
  logic [TRY_W-1:0] tries;
  logic [31:0]      n;
  logic [31:0]      lo;
  logic [31:0]      used;
  logic             raw;
  logic [31:0]      masked;
  logic             hit;
  logic             last;
  logic             finish;
  logic             accept;
  logic             seed_ok;
  logic [31:0]      span;

  assign ptr_inc   = (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
  assign ram_raddr = ptr_inc;
  assign masked    = word & used;
  assign hit       = raw || (masked <= n);
  assign last      = (tries == TRY_W'(MAX_TRIES - 1));
  assign finish    = hit || last;
  assign accept    = start && (state == ST_IDLE);
  assign seed_ok   = (32'(seed_index) < 32'(LAG_DEPTH));
  assign span      = $unsigned(range_high) - $unsigned(range_low);
  assign busy      = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ram_we     = 1'b0;
    ram_waddr  = ptr_inc;
    ram_wdata  = word;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (op_t'(op) == OP_LOAD) begin
            ram_we    = seed_ok;
            ram_waddr = PTR_W'(seed_index);
            ram_wdata = seed_word;
            ctl.seed  = 1'b1;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        ctl.add    = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        ctl.fin    = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        ram_we     = 1'b1;
        state_next = finish ? ST_IDLE : ST_READ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= PTR_LAST;
      tries <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        tries <= '0;
        if (op_t'(op) == OP_LOAD) begin
          ptr <= PTR_LAST;
        end
      end
      if (state == ST_CHECK) begin
        ptr   <= ptr_inc;
        tries <= tries + TRY_W'(1);
        done  <= finish;
      end
    end
  end

  // Draw parameters; a raw draw takes every output as is
  always_ff @(posedge clk) begin
    if (accept) begin
      raw <= (op_t'(op) == OP_RAW);
      case (op_t'(op))
        OP_RANGE: begin
          n    <= span;
          lo   <= $unsigned(range_low);
          used <= cover_mask(span);
        end
        OP_BOUNDED: begin
          n    <= bound;
          lo   <= '0;
          used <= cover_mask(bound);
        end
        default: begin
          n    <= ALL_ONES;
          lo   <= '0;
          used <= ALL_ONES;
        end
      endcase
    end
    if (state == ST_CHECK) begin
      // saturate to n when every try was rejected
      value <= lo + (hit ? masked : n);
    end
  end

endmodule

// File: rtl/cmwc_random_generator_top.sv
// Top level of the CMWC random generator: APB register, sequencer, unit, lag table.
// Depends on cmwc_pkg, cmwc_ram, cmwc_step and cmwc_ctrl.
//
//   channel   handshake                 payload
//   command   start / busy              op, seed_index, seed_word, bound,
//                                       range_low, range_high
//   result    done (one-cycle strobe)   value
//   config    APB psel/penable/pwrite   paddr, pwdata, prdata (multiplier)
//
// A load writes the word at the accept edge and busy stays low.
// Each try of a draw steps through the read, multiply, add, fold and check states in
// turn, as there is one multiplier and a single table read port; a bounded or range
// draw makes at most 64 tries, after which the result saturates to the bound.
// done rises with busy falling; a new command may be accepted in that same cycle.
// Reset sets the multiplier to 18782, the carry to 123 and the pointer to the last
// entry; the lag table is not cleared and must be loaded before the first draw.
module cmwc_random_generator_top import cmwc_pkg::*; #(
  parameter int unsigned LAG_DEPTH = LAG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [11:0]        seed_index,
  input  logic [31:0]        seed_word,
  input  logic [31:0]        bound,
  input  logic signed [31:0] range_low,
  input  logic signed [31:0] range_high,
  output logic               done,
  output logic [31:0]        value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned PTR_W = $clog2(LAG_DEPTH);

  logic [31:0]      multiplier;
  logic             reg_hit;
  step_ctl_t        ctl;
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic [PTR_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;
  logic [31:0]      word;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_MULT);
  assign prdata  = reg_hit ? multiplier : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= MULT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      multiplier <= pwdata;
    end
  end

  cmwc_ram #(
    .WIDTH (32),
    .DEPTH (LAG_DEPTH)
  ) u_lag_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cmwc_step u_step (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .multiplier (multiplier),
    .lag_word   (ram_rdata),
    .word       (word)
  );

  cmwc_ctrl #(
    .LAG_DEPTH (LAG_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op),
    .seed_index (seed_index),
    .seed_word  (seed_word),
    .bound      (bound),
    .range_low  (range_low),
    .range_high (range_high),
    .word       (word),
    .ctl        (ctl),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .busy       (busy),
    .done       (done),
    .value      (value)
  );

endmodule

// File: rtl/cmwc_checker.sv
// Port-level checker for the CMWC generator, bound to the top level.
// Depends on cmwc_pkg and cmwc_random_generator_top.
module cmwc_checker import cmwc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] op,
  input logic       done,
  input logic       pready
);

  // A result closes a draw: it follows a busy cycle and frees the block
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result strobe without a draw in progress");

  a_load_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op_t'(op) == OP_LOAD)) |=> (!busy && !done))
    else $error("load transaction made the block busy or gave a result");

  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op_t'(op) != OP_LOAD)) |=> (busy && !done))
    else $error("draw transaction did not start work");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind cmwc_random_generator_top cmwc_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .op     (op),
  .done   (done),
  .pready (pready)
);
